// ===== rtl/pdt_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the page descriptor table
// no dependencies
package pdt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam logic [31:0] STACK_TOP_RESET   = 32'hC000_0000;
  localparam logic [31:0] STACK_LIMIT_RESET = 32'h0080_0000;
  // push and pusha touch the stack this far below the stack pointer
  localparam logic [31:0] PUSH_OFS  = 32'd4;
  localparam logic [31:0] PUSHA_OFS = 32'd32;

  localparam logic CFG_STACK_TOP   = 1'b0;
  localparam logic CFG_STACK_LIMIT = 1'b1;

  localparam logic KIND_FILE = 1'b0;
  localparam logic KIND_ZERO = 1'b1;

  typedef enum logic [2:0] {
    ACT_INS_FILE = 3'd0,
    ACT_INS_ZERO = 3'd1,
    ACT_LOOKUP   = 3'd2,
    ACT_DELETE   = 3'd3,
    ACT_STACK    = 3'd4,
    ACT_CLEAR    = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  file_handle;
    logic [30:0] file_pos;
    logic [12:0] bytes_from_file;
    logic [12:0] bytes_zero_fill;
    logic        may_write;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [31:0] fault_address;
    logic [31:0] frame_sp;
    logic [31:0] saved_sp;
    logic        from_user;
  } stack_req_t;

endpackage

// ===== rtl/pdt_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with one registered read port
// no dependencies
module pdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pdt_stack_chk.sv =====
`timescale 1ns / 1ps
// stack growth check, result registered when the word is taken
// depends on pdt_pkg
module pdt_stack_chk (
  input  logic               clk,
  input  logic               load,
  input  logic [31:0]        stack_top,
  input  logic [31:0]        stack_limit,
  input  pdt_pkg::stack_req_t req,
  output logic               grant_r
);

  logic [31:0] lower;
  logic [31:0] cur_sp;
  logic        in_region;
  logic        near_sp;
  logic        grant_nxt;

  always_comb begin
    lower     = (stack_limit > stack_top) ? 32'd0 : stack_top - stack_limit;
    cur_sp    = req.from_user ? req.frame_sp : req.saved_sp;
    in_region = (req.fault_address >= lower) && (req.fault_address < stack_top);
    near_sp   = (req.fault_address >= cur_sp)
             || (req.fault_address == req.frame_sp - pdt_pkg::PUSH_OFS)
             || (req.fault_address == req.frame_sp - pdt_pkg::PUSHA_OFS);
    grant_nxt = in_region && near_sp;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grant_r <= grant_nxt;
    end
  end

endmodule

// ===== rtl/page_descriptor_table_top.sv =====
`timescale 1ns / 1ps
// page descriptor table: keyed store of page descriptors with stack check
// depends on pdt_pkg, pdt_ram, pdt_stack_chk
//
// usage
// - a command word is taken at a clock edge with start high and busy low;
//   busy stays high until the result word has been formed
// - every command gives exactly one result word, shown for one cycle with
//   out_valid high; the receiver cannot stall, so it must sample it then
// - keys live in one synchronous ram, descriptors in a second one; valid
//   bits are flops. a command that needs the table scans the slots in
//   order until a key hit or the last slot, one ram read per cycle; each
//   key is compared in the cycle after its read; lowest free slot is noted
// - sequence: clear and unused codes go from accept straight to the
//   finish step; insert, lookup, delete and stack check scan the table
//   first, and a key hit ends the scan early. the single ram read port
//   makes the scan visit the slots one at a time
// - one command in flight at a time; the next may start in the cycle in
//   which the result is shown
// - reset clears all valid bits at once (table empty) and loads stack_top
//   and stack_limit with their defaults; no clearing pass is needed
// - configuration: cfg_we with cfg_index 0 writes stack_top, 1 writes
//   stack_limit; write only while idle
module page_descriptor_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_page_addr,
  input  logic [7:0]  in_file_handle,
  input  logic [30:0] in_file_pos,
  input  logic [12:0] in_bytes_from_file,
  input  logic [12:0] in_bytes_zero_fill,
  input  logic        in_may_write,
  input  logic [31:0] in_fault_address,
  input  logic [31:0] in_frame_sp,
  input  logic [31:0] in_saved_sp,
  input  logic        in_from_user,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_ok,
  output logic        out_found,
  output logic        out_hit_kind,
  output logic [7:0]  out_hit_file_handle,
  output logic [30:0] out_hit_file_pos,
  output logic [12:0] out_hit_bytes_from_file,
  output logic [12:0] out_hit_bytes_zero_fill,
  output logic        out_hit_may_write
);

  localparam int N = pdt_pkg::TABLE_ENTRIES;
  localparam int W = pdt_pkg::IDX_W;
  localparam logic [W-1:0] LAST_IDX = W'(N - 1);

  pdt_pkg::state_t state_r, state_nxt;

  // config registers
  logic [31:0] stack_top_r;
  logic [31:0] stack_limit_r;

  // latched command word
  logic [2:0]      act_r;
  logic [31:0]     key_r;
  pdt_pkg::entry_t ent_r;

  // scan bookkeeping
  logic [N-1:0]    valid_r;
  logic [W-1:0]    rd_idx_r;
  logic            rd_done_r;
  logic            cmp_v_r;
  logic [W-1:0]    cmp_idx_r;
  logic            hit_r;
  logic [W-1:0]    hit_idx_r;
  pdt_pkg::entry_t hit_ent_r;
  logic            free_v_r;
  logic [W-1:0]    free_idx_r;

  logic            accept;
  logic            issue;
  logic            cmp_hit;
  logic            cmp_free;
  logic            scan_end;
  logic [31:0]     key_rdata;
  logic [pdt_pkg::ENTRY_W-1:0] ent_rdata;
  logic            grant_r;
  logic            do_insert;
  logic            ins_ok;
  pdt_pkg::entry_t wr_ent;
  pdt_pkg::stack_req_t sreq;
  logic            found_nxt;
  pdt_pkg::entry_t res_ent_nxt;

  assign accept = start && !busy;
  assign busy   = (state_r != pdt_pkg::ST_IDLE);
  assign issue  = (state_r == pdt_pkg::ST_SCAN) && !rd_done_r;

  assign cmp_hit  = cmp_v_r && valid_r[cmp_idx_r] && (key_rdata == key_r);
  assign cmp_free = cmp_v_r && !valid_r[cmp_idx_r];
  assign scan_end = cmp_v_r && (cmp_hit || (cmp_idx_r == LAST_IDX));

  assign sreq = '{fault_address: in_fault_address, frame_sp: in_frame_sp,
                  saved_sp: in_saved_sp, from_user: in_from_user};

  pdt_stack_chk u_stack (
    .clk         (clk),
    .load        (accept),
    .stack_top   (stack_top_r),
    .stack_limit (stack_limit_r),
    .req         (sreq),
    .grant_r     (grant_r)
  );

  // insert decision at the end of the scan
  always_comb begin
    do_insert = 1'b0;
    ins_ok    = 1'b0;
    wr_ent    = '0;
    wr_ent.kind = pdt_pkg::KIND_ZERO;
    if (state_r == pdt_pkg::ST_FIN) begin
      case (act_r)
        pdt_pkg::ACT_INS_FILE: begin
          do_insert = !hit_r && free_v_r;
          ins_ok    = do_insert;
          wr_ent    = ent_r;
        end
        pdt_pkg::ACT_INS_ZERO: begin
          do_insert = !hit_r && free_v_r;
          ins_ok    = do_insert;
        end
        pdt_pkg::ACT_STACK: begin
          // granted even when the table has no room left
          do_insert = grant_r && !hit_r && free_v_r;
          ins_ok    = grant_r && !hit_r;
        end
        default: begin
          do_insert = 1'b0;
        end
      endcase
    end
  end

  pdt_ram #(.WIDTH(32), .DEPTH(N)) u_key_ram (
    .clk   (clk),
    .we    (do_insert),
    .waddr (free_idx_r),
    .wdata (key_r),
    .raddr (rd_idx_r),
    .rdata (key_rdata)
  );

  pdt_ram #(.WIDTH(pdt_pkg::ENTRY_W), .DEPTH(N)) u_ent_ram (
    .clk   (clk),
    .we    (do_insert),
    .waddr (free_idx_r),
    .wdata (wr_ent),
    .raddr (rd_idx_r),
    .rdata (ent_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pdt_pkg::ST_IDLE: begin
        if (accept) begin
          // clear and unused codes skip the scan
          if (!(in_action inside {[pdt_pkg::ACT_INS_FILE:pdt_pkg::ACT_STACK]})) begin
            state_nxt = pdt_pkg::ST_FIN;
          end else begin
            state_nxt = pdt_pkg::ST_SCAN;
          end
        end
      end
      pdt_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = pdt_pkg::ST_FIN;
        end
      end
      pdt_pkg::ST_FIN: begin
        state_nxt = pdt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_top_r   <= pdt_pkg::STACK_TOP_RESET;
      stack_limit_r <= pdt_pkg::STACK_LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == pdt_pkg::CFG_STACK_TOP) begin
        stack_top_r <= cfg_wdata;
      end else begin
        stack_limit_r <= cfg_wdata;
      end
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r                 <= in_action;
      key_r                 <= in_page_addr;
      ent_r.kind            <= pdt_pkg::KIND_FILE;
      ent_r.file_handle     <= in_file_handle;
      ent_r.file_pos        <= in_file_pos;
      ent_r.bytes_from_file <= in_bytes_from_file;
      ent_r.bytes_zero_fill <= in_bytes_zero_fill;
      ent_r.may_write       <= in_may_write;
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      rd_done_r <= 1'b0;
      cmp_v_r   <= 1'b0;
      hit_r     <= 1'b0;
      free_v_r  <= 1'b0;
    end else if (accept) begin
      rd_idx_r  <= '0;
      rd_done_r <= 1'b0;
      cmp_v_r   <= 1'b0;
      hit_r     <= 1'b0;
      free_v_r  <= 1'b0;
    end else if (state_r == pdt_pkg::ST_SCAN) begin
      if (scan_end) begin
        cmp_v_r   <= 1'b0;
        rd_done_r <= 1'b1;
      end else begin
        cmp_v_r <= issue;
        if (issue) begin
          rd_done_r <= (rd_idx_r == LAST_IDX);
          rd_idx_r  <= rd_idx_r + W'(1);
        end
      end
      if (cmp_hit) begin
        hit_r <= 1'b1;
      end
      if (cmp_free && !free_v_r) begin
        free_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_idx_r;
    if (cmp_hit) begin
      hit_idx_r <= cmp_idx_r;
      hit_ent_r <= ent_rdata;
    end
    if (cmp_free && !free_v_r) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  // valid bits: set on insert, cleared on delete or clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (state_r == pdt_pkg::ST_FIN) begin
      if (act_r == pdt_pkg::ACT_CLEAR) begin
        valid_r <= '0;
      end else if ((act_r == pdt_pkg::ACT_DELETE) && hit_r) begin
        valid_r[hit_idx_r] <= 1'b0;
      end else if (do_insert) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == pdt_pkg::ST_FIN);
    end
  end

  // found flag and stored fields; unused fields stay zero
  always_comb begin
    found_nxt   = 1'b0;
    res_ent_nxt = '0;
    case (act_r)
      pdt_pkg::ACT_INS_FILE, pdt_pkg::ACT_INS_ZERO, pdt_pkg::ACT_DELETE: begin
        found_nxt = hit_r;
      end
      pdt_pkg::ACT_LOOKUP: begin
        found_nxt = hit_r;
        if (hit_r) begin
          res_ent_nxt = hit_ent_r;
        end
      end
      default: begin
        found_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == pdt_pkg::ST_FIN) begin
      out_ok                  <= ins_ok;
      out_found               <= found_nxt;
      out_hit_kind            <= res_ent_nxt.kind;
      out_hit_file_handle     <= res_ent_nxt.file_handle;
      out_hit_file_pos        <= res_ent_nxt.file_pos;
      out_hit_bytes_from_file <= res_ent_nxt.bytes_from_file;
      out_hit_bytes_zero_fill <= res_ent_nxt.bytes_zero_fill;
      out_hit_may_write       <= res_ent_nxt.may_write;
    end
  end

  // a result word is shown for a single cycle
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a result only follows the finish step
  a_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == pdt_pkg::ST_FIN))
    else $error("result without finish step");

  // a hit refers to a live slot
  a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == pdt_pkg::ST_FIN) && hit_r) |-> valid_r[hit_idx_r])
    else $error("hit on an invalid slot");

  // the free slot picked for an insert is really free
  a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |-> !valid_r[free_idx_r])
    else $error("insert over a live slot");

endmodule
